// ===== hw/rtl/phd_pkg.sv =====
// shared types and constants for the peak hold falling dot block
`default_nettype none

package phd_pkg;

    // number of channels with stored state
    localparam int CHANNELS = 16;

    // field widths
    localparam int CH_W     = 4;
    localparam int LEVEL_W  = 8;
    localparam int PERIOD_W = 4;
    localparam int HOLD_W   = 8;
    localparam int ACCEL_W  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FALL_PERIOD_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INTERVAL    = 2'd2;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] FALL_PERIOD_START_RST = 4'd3;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST        = 8'd7;
    localparam logic [ACCEL_W-1:0]  ACCEL_INTERVAL_RST    = 4'd1;

    // per channel state
    typedef struct packed {
        logic [LEVEL_W-1:0]  dot;
        logic [PERIOD_W-1:0] period;
        logic [HOLD_W-1:0]   hold;
        logic [PERIOD_W-1:0] countdown;
        logic [ACCEL_W-1:0]  accel;
    } t_chan_state;

endpackage

`default_nettype wire

// ===== hw/rtl/phd_if.sv =====
// stream interfaces for levels, results and configuration writes
`default_nettype none

interface phd_in_if;
    import phd_pkg::*;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    modport source (output valid, output channel, output level, input ready);
    modport sink   (input valid, input channel, input level, output ready);
endinterface

interface phd_out_if;
    import phd_pkg::*;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel_out;
    logic [LEVEL_W-1:0] dot_position;
    modport source (output valid, output channel_out, output dot_position, input ready);
    modport sink   (input valid, input channel_out, input dot_position, output ready);
endinterface

interface phd_cfg_if;
    import phd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/peak_hold_falling_dot.sv =====
// peak_hold_falling_dot: per channel peak marker with accelerating fall
//
// i_in carries a channel index and its current bar level; o_res returns the
// channel and the updated dot height, one result per accepted transaction.
// i_cfg writes fall_period_start (0), hold_ticks (1) and accel_interval (2);
// it is always ready and should only be used while the block is idle.
// An accepted level lands in an input register; once the result register
// is free, the channel state is read, updated and written back while the
// result register loads and offers the result. Throughput is one transaction
// per cycle while the receiver keeps up, also for repeated hits on the same
// channel, since each state write back ends before the next item reads it.
// When the receiver stalls, the result register holds and the input
// register holds one more item; i_in.ready then drops.
// Synchronous active low reset clears all channel state to zero, loads the
// configuration defaults (3, 7, 1) and empties both registers.
`default_nettype none

module peak_hold_falling_dot (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    phd_in_if.sink     i_in,
    phd_cfg_if.sink    i_cfg,
    phd_out_if.source  o_res
);
    import phd_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_fall_start;
    logic [HOLD_W-1:0]   r_hold_ticks;
    logic [ACCEL_W-1:0]  r_accel_int;

    // input stage
    logic                r_in_vld;
    logic [CH_W-1:0]     r_ch;
    logic [LEVEL_W-1:0]  r_lvl;

    // result stage
    logic                r_out_vld;
    logic [CH_W-1:0]     r_out_ch;
    logic [LEVEL_W-1:0]  r_out_dot;

    // channel state
    t_chan_state         r_state [CHANNELS];

    logic                out_free;
    logic                adv;
    logic                in_range;
    t_chan_state         cur;
    t_chan_state         n_state;
    logic [LEVEL_W-1:0]  n_dot;

    // pipeline flow control
    assign out_free    = !r_out_vld || o_res.ready;
    assign adv         = r_in_vld && out_free;
    assign i_in.ready  = !r_in_vld || out_free;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_out_vld;
    assign o_res.channel_out  = r_out_ch;
    assign o_res.dot_position = r_out_dot;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_start <= FALL_PERIOD_START_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
            r_accel_int  <= ACCEL_INTERVAL_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_FALL_PERIOD_START) begin
                r_fall_start <= i_cfg.data[PERIOD_W-1:0];
            end else if (i_cfg.index == REG_HOLD_TICKS) begin
                r_hold_ticks <= i_cfg.data[HOLD_W-1:0];
            end else if (i_cfg.index == REG_ACCEL_INTERVAL) begin
                r_accel_int <= i_cfg.data[ACCEL_W-1:0];
            end
        end
    end

    // channel update
    assign in_range = ({1'b0, r_ch} < (CH_W+1)'(CHANNELS));
    assign cur      = r_state[r_ch];

    always_comb begin
        n_state = cur;
        priority if (cur.dot <= r_lvl) begin
            // new peak: jump and reload everything
            n_state.dot       = r_lvl;
            n_state.period    = r_fall_start;
            n_state.hold      = r_hold_ticks;
            n_state.countdown = r_fall_start;
            n_state.accel     = r_accel_int;
        end else if (cur.countdown == '0) begin
            // one step down, then maybe shorten the period
            n_state.dot       = cur.dot - 1'b1;
            n_state.countdown = cur.period;
            if (cur.accel != '0) begin
                n_state.accel = cur.accel - 1'b1;
            end else begin
                if (cur.period != '0) begin
                    n_state.period = cur.period - 1'b1;
                end
                n_state.accel = r_accel_int;
            end
        end else if (cur.hold != '0) begin
            n_state.hold = cur.hold - 1'b1;
        end else begin
            n_state.countdown = cur.countdown - 1'b1;
        end
    end

    assign n_dot = in_range ? n_state.dot : '0;

    // state write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_state[k] <= '0;
            end
        end else if (adv && in_range) begin
            r_state[r_ch] <= n_state;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch  <= i_in.channel;
            r_lvl <= i_in.level;
        end
        if (adv) begin
            r_out_ch  <= r_ch;
            r_out_dot <= n_dot;
        end
    end

`ifndef SYNTHESIS
    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_vld && !r_out_vld))
        else $error("pipeline not empty after reset");

    // the dot never ends below the level that updated it
    a_dot_above_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && in_range) |-> (n_state.dot >= r_lvl))
        else $error("dot below level");

    // a drop only happens when the countdown has run out
    a_drop_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && in_range && (n_state.dot < cur.dot)) |-> (cur.countdown == '0))
        else $error("dot dropped with countdown running");
`endif

endmodule

`default_nettype wire
